// ===== rtl/ogr_pkg.sv =====
// Shared constants, types, font ROM and helpers for the outlined glyph renderer.
`default_nettype none

package ogr_pkg;

    localparam int unsigned MAX_MAP_SIZE_DEF = 256;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned COORD_W   = 9;
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned INDEX_W   = 16;

    localparam int unsigned CELL_W      = 7;
    localparam int unsigned CELL_H      = 9;
    localparam int unsigned CELL_PIX    = CELL_W * CELL_H;
    localparam int unsigned GLYPH_W     = 5;
    localparam int unsigned GLYPH_H     = 7;
    localparam int unsigned GLYPH_COUNT = 36;
    localparam int unsigned GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int unsigned DX_W        = $clog2(CELL_W);

    localparam logic [CFG_W-1:0] MAP_SIZE_RESET = 9'd144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } t_cfg_reg;

    localparam logic KIND_FG      = 1'b0;
    localparam logic KIND_OUTLINE = 1'b1;

    localparam logic [CODE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CODE_W-1:0] CHAR_A       = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_Z       = 8'h5A;
    localparam logic [CODE_W-1:0] DIGIT_GLYPHS = 8'd10;

    typedef logic [GLYPH_W-1:0] t_glyph_row;

    // Row-major 5x7 font; bit 4 of a row is the leftmost column.
    localparam t_glyph_row GLYPH_ROM [GLYPH_COUNT][GLYPH_H] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
    };

    // Per cell position (bit = row * CELL_W + column): write needed, and glyph pixel.
    typedef struct packed {
        logic [CELL_PIX-1:0] emit;
        logic [CELL_PIX-1:0] fg;
    } t_cell_mask;

    function automatic logic is_digit(input logic [CODE_W-1:0] code);
        return (code >= CHAR_ZERO) && (code <= CHAR_NINE);
    endfunction

    function automatic logic glyph_supported(input logic [CODE_W-1:0] code);
        return is_digit(code) || ((code >= CHAR_A) && (code <= CHAR_Z));
    endfunction

    // Font slot of a supported code; unsupported codes map to slot 0 and are masked.
    function automatic logic [GLYPH_IDX_W-1:0] glyph_num(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] slot;
        if (is_digit(code)) begin
            slot = code - CHAR_ZERO;
        end else if (glyph_supported(code)) begin
            slot = code - CHAR_A + DIGIT_GLYPHS;
        end else begin
            slot = '0;
        end
        return slot[GLYPH_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ogr_if.sv =====
// Request channels of the outlined glyph renderer: character in, pixel write out.
`default_nettype none

interface ogr_char_if;
    logic                                 valid;
    logic                                 ready;
    logic [ogr_pkg::CODE_W-1:0]           char_code;
    logic signed [ogr_pkg::COORD_W-1:0]   top_left_x;
    logic signed [ogr_pkg::COORD_W-1:0]   top_left_y;

    modport source (output valid, char_code, top_left_x, top_left_y, input ready);
    modport sink   (input valid, char_code, top_left_x, top_left_y, output ready);
endinterface

interface ogr_pix_if;
    logic                          valid;
    logic                          ready;
    logic [ogr_pkg::INDEX_W-1:0]   pixel_index;
    logic                          pixel_kind;
    logic                          last_write;

    modport source (output valid, pixel_index, pixel_kind, last_write, input ready);
    modport sink   (input valid, pixel_index, pixel_kind, last_write, output ready);
endinterface

`default_nettype wire

// ===== rtl/ogr_cell_mask.sv =====
// Cell mask: glyph lookup, one-pixel outline dilation and map clipping for a 7x9 cell.
`default_nettype none

module ogr_cell_mask #(
    parameter int unsigned MAX_MAP_SIZE = ogr_pkg::MAX_MAP_SIZE_DEF
) (
    input  logic [ogr_pkg::CODE_W-1:0]          i_char_code,
    input  logic signed [ogr_pkg::COORD_W-1:0]  i_top_left_x,
    input  logic signed [ogr_pkg::COORD_W-1:0]  i_top_left_y,
    input  logic [$clog2(MAX_MAP_SIZE+1)-1:0]   i_map_w,
    input  logic [$clog2(MAX_MAP_SIZE+1)-1:0]   i_map_h,
    output ogr_pkg::t_cell_mask                 o_mask
);

    localparam int unsigned SW = $clog2(MAX_MAP_SIZE + 1);
    localparam int unsigned CW = ((SW > ogr_pkg::COORD_W) ? SW : ogr_pkg::COORD_W) + 2;

    ogr_pkg::t_glyph_row                             glyph [ogr_pkg::GLYPH_H];
    logic                                            supported;
    logic [ogr_pkg::CELL_H-1:0][ogr_pkg::CELL_W-1:0] grid;
    logic [ogr_pkg::CELL_W-1:0]                      col_ok;
    logic [ogr_pkg::CELL_H-1:0]                      row_ok;
    logic signed [CW-1:0]                            px;
    logic signed [CW-1:0]                            py;
    logic                                            near;

    always_comb begin
        glyph     = ogr_pkg::GLYPH_ROM[ogr_pkg::glyph_num(i_char_code)];
        supported = ogr_pkg::glyph_supported(i_char_code);

        // Glyph sits inside the cell with a blank margin all round.
        grid = '0;
        for (int r = 0; r < ogr_pkg::GLYPH_H; r++) begin
            for (int c = 0; c < ogr_pkg::GLYPH_W; c++) begin
                grid[r+1][c+1] = glyph[r][ogr_pkg::GLYPH_W-1-c] & supported;
            end
        end

        px = '0;
        for (int dx = 0; dx < ogr_pkg::CELL_W; dx++) begin
            px         = CW'(i_top_left_x) + CW'(dx);
            col_ok[dx] = (px >= 0) && (px < $signed(CW'(i_map_w)));
        end
        py = '0;
        for (int dy = 0; dy < ogr_pkg::CELL_H; dy++) begin
            py         = CW'(i_top_left_y) + CW'(dy);
            row_ok[dy] = (py >= 0) && (py < $signed(CW'(i_map_h)));
        end

        o_mask = '0;
        near   = 1'b0;
        for (int dy = 0; dy < ogr_pkg::CELL_H; dy++) begin
            for (int dx = 0; dx < ogr_pkg::CELL_W; dx++) begin
                near = 1'b0;
                for (int ny = dy - 1; ny <= dy + 1; ny++) begin
                    for (int nx = dx - 1; nx <= dx + 1; nx++) begin
                        if (ny >= 0 && ny < ogr_pkg::CELL_H && nx >= 0 && nx < ogr_pkg::CELL_W) begin
                            near = near | grid[ny][nx];
                        end
                    end
                end
                o_mask.fg[dy*ogr_pkg::CELL_W+dx]   = grid[dy][dx];
                o_mask.emit[dy*ogr_pkg::CELL_W+dx] = near & col_ok[dx] & row_ok[dy];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/outlined_glyph_renderer.sv =====
// Outlined glyph renderer top level: config, input register, cell sweep, output register.
// Each accepted character is held in an input register, turned into a 63-bit write mask of its
// 7x9 cell, then swept one cell position per cycle, row by row, left to right, except while a
// stalled output holds the sweep at a position that writes; positions that need a write produce
// one pixel request each, with last_write on the final one. The sweep stops right after the last
// position that writes. The next character is accepted while the sweep runs and is loaded the
// cycle the sweep frees, so the sweep passes from one item to the next without a gap. On an idle
// block the first write goes from the input register through the sweep to the output register.
// The pixel index is formed by an adder stepping by one per column and by map_width per row,
// wrapping at 16 bits. map_width/map_height must be written only while idle, which the block
// itself does not enforce; values above MAX_MAP_SIZE act as MAX_MAP_SIZE.
`default_nettype none

module outlined_glyph_renderer #(
    parameter int unsigned MAX_MAP_SIZE = ogr_pkg::MAX_MAP_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ogr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ogr_pkg::CFG_W-1:0]         i_cfg_data,
    ogr_char_if.sink                          i_char,
    ogr_pix_if.source                         o_pix
);

    localparam int unsigned SW  = $clog2(MAX_MAP_SIZE + 1);
    localparam int unsigned CLW = ((SW > ogr_pkg::CFG_W) ? SW : ogr_pkg::CFG_W) + 1;
    localparam int unsigned IW  = ogr_pkg::INDEX_W;
    localparam int unsigned NP  = ogr_pkg::CELL_PIX;

    // configuration
    logic [ogr_pkg::CFG_W-1:0] r_map_width;
    logic [ogr_pkg::CFG_W-1:0] r_map_height;
    logic [SW-1:0]             map_w;
    logic [SW-1:0]             map_h;

    // input register
    logic                                 r_in_vld;
    logic [ogr_pkg::CODE_W-1:0]           r_in_code;
    logic signed [ogr_pkg::COORD_W-1:0]   r_in_x;
    logic signed [ogr_pkg::COORD_W-1:0]   r_in_y;

    // sweep
    logic                          r_sw_busy;
    logic [NP-1:0]                 r_mask;
    logic [NP-1:0]                 r_fg;
    logic [ogr_pkg::DX_W-1:0]      r_dx;
    logic [IW-1:0]                 r_idx;
    logic [IW-1:0]                 r_row;
    logic [IW-1:0]                 n_row;

    // output register
    logic            r_out_vld;
    logic [IW-1:0]   r_out_index;
    logic            r_out_kind;
    logic            r_out_last;

    ogr_pkg::t_cell_mask   cell_mask;
    logic [IW-1:0]         w16;
    logic [IW-1:0]         base;
    logic                  out_free;
    logic                  rest_zero;
    logic                  sw_step;
    logic                  sw_emit;
    logic                  sw_free;
    logic                  load;
    logic                  in_ready;

    always_comb begin
        map_w = (CLW'(r_map_width) > CLW'(MAX_MAP_SIZE)) ? SW'(MAX_MAP_SIZE) : SW'(r_map_width);
        map_h = (CLW'(r_map_height) > CLW'(MAX_MAP_SIZE)) ? SW'(MAX_MAP_SIZE) : SW'(r_map_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= ogr_pkg::MAP_SIZE_RESET;
            r_map_height <= ogr_pkg::MAP_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (ogr_pkg::t_cfg_reg'(i_cfg_idx))
                ogr_pkg::REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                ogr_pkg::REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ogr_cell_mask #(
        .MAX_MAP_SIZE (MAX_MAP_SIZE)
    ) u_cell_mask (
        .i_char_code  (r_in_code),
        .i_top_left_x (r_in_x),
        .i_top_left_y (r_in_y),
        .i_map_w      (map_w),
        .i_map_h      (map_h),
        .o_mask       (cell_mask)
    );

    always_comb begin
        w16       = IW'(map_w);
        // index of the cell's top-left corner, modulo 2^16
        base      = IW'(r_in_x) + IW'(w16 * IW'(r_in_y));
        n_row     = r_row + w16;
        out_free  = !r_out_vld || o_pix.ready;
        rest_zero = ~|r_mask[NP-1:1];
        sw_step   = r_sw_busy && (!r_mask[0] || out_free);
        sw_emit   = r_sw_busy && r_mask[0] && out_free;
        sw_free   = !r_sw_busy || (sw_step && rest_zero);
        load      = r_in_vld && sw_free;
        in_ready  = !r_in_vld || load;
    end

    assign i_char.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_char.valid && in_ready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && in_ready) begin
            r_in_code <= i_char.char_code;
            r_in_x    <= i_char.top_left_x;
            r_in_y    <= i_char.top_left_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_busy <= 1'b0;
        end else if (load) begin
            r_sw_busy <= |cell_mask.emit;
        end else if (sw_step && rest_zero) begin
            r_sw_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask <= cell_mask.emit;
            r_fg   <= cell_mask.fg;
            r_dx   <= '0;
            r_idx  <= base;
            r_row  <= base;
        end else if (sw_step) begin
            r_mask <= r_mask >> 1;
            r_fg   <= r_fg >> 1;
            if (r_dx == ogr_pkg::DX_W'(ogr_pkg::CELL_W - 1)) begin
                r_dx  <= '0;
                r_row <= n_row;
                r_idx <= n_row;
            end else begin
                r_dx  <= r_dx + 1'b1;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (sw_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sw_emit) begin
            r_out_index <= r_idx;
            r_out_kind  <= r_fg[0] ? ogr_pkg::KIND_FG : ogr_pkg::KIND_OUTLINE;
            r_out_last  <= rest_zero;
        end
    end

    assign o_pix.valid       = r_out_vld;
    assign o_pix.pixel_index = r_out_index;
    assign o_pix.pixel_kind  = r_out_kind;
    assign o_pix.last_write  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/ogr_checker.sv =====
// Port-level checks for the outlined glyph renderer, bound to the top level.
`default_nettype none

module ogr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ogr_pkg::INDEX_W-1:0]   i_pixel_index,
    input logic                          i_pixel_kind,
    input logic                          i_last_write
);

    // reset empties the output register
    a_rst_out_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("pixel request pending after reset");

    // reset empties the input register, so a request is taken at once
    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // no write is produced before a character has gone through the input, sweep and output registers
    a_first_latency: assert property (@(posedge i_clk)
        !i_rst_n |=> ##1 !i_out_valid)
        else $error("pixel request too soon after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_index)
            && $stable(i_pixel_kind) && $stable(i_last_write))
        else $error("stalled pixel request changed");

endmodule

bind outlined_glyph_renderer ogr_checker u_ogr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_char.ready),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_pixel_index (o_pix.pixel_index),
    .i_pixel_kind  (o_pix.pixel_kind),
    .i_last_write  (o_pix.last_write)
);

`default_nettype wire
